// ===== design/lphm_pkg.sv =====
// ============================================================================
// Linear probe hash map package
// Shared widths, command and status codes, and the key mixing constants.
// ============================================================================
package lphm_pkg;

    localparam int SLOTS_DEF   = 1024;
    localparam int KEY_W_DEF   = 64;
    localparam int VALUE_W     = 64;
    localparam int HASH_W      = 64;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;
    localparam int MAX_W       = 10;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 10'd512;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd3;

    // 64-bit finalizer constants and shift amounts.
    localparam logic [HASH_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

endpackage

// ===== design/linear_probe_hash_map_core.sv =====
// ============================================================================
// Linear probe hash map core
// Key and value memories with a sequencer for lookup, set and remove.
// ============================================================================
// A zero key or an unused command answers in the cycle after start.
// Otherwise the key passes through the hash unit, the first slot read and the
// result register, with one more read for each further slot probed; a remove
// then walks the rest of the cluster, and each key that follows in it is
// rehashed by the same hash unit.
// One item at a time: busy stays high until the result strobe, and the next
// start is taken in the cycle the strobe shows. Results cannot be stalled.
// After reset the key memory is cleared one slot a cycle, with busy high.
module linear_probe_hash_map_core #(
    parameter int SLOTS     = lphm_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH = lphm_pkg::KEY_W_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lphm_pkg::CMD_W-1:0]        cmd,
    input  logic [63:0]                       key,
    input  logic [lphm_pkg::VALUE_W-1:0]      value,
    output logic                              done,
    output logic [lphm_pkg::STATUS_W-1:0]     status,
    output logic [lphm_pkg::VALUE_W-1:0]      read_value,
    output logic [lphm_pkg::COUNT_OUT_W-1:0]  stored_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lphm_pkg::MAX_W-1:0]        cfg_data
);

    import lphm_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS);
    localparam int CMP_W = 17;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_RHASH = 7'b0100000,
        S_MVCLR = 7'b1000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     clr_reg;
    logic [IDX_W-1:0]     clr_next;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     ptr_next;
    logic [IDX_W-1:0]     hole_reg;
    logic [IDX_W-1:0]     hole_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [MAX_W-1:0]     max_entries_reg;
    logic                 done_reg;
    logic                 done_next;

    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [KEY_WIDTH-1:0] mk_reg;
    logic [KEY_WIDTH-1:0] mk_next;
    logic [VALUE_W-1:0]   mv_reg;
    logic [VALUE_W-1:0]   mv_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [VALUE_W-1:0]   read_value_reg;
    logic [VALUE_W-1:0]   read_value_next;

    logic                 accept;
    logic                 key_in_zero;
    logic                 kwe;
    logic [IDX_W-1:0]     kwaddr;
    logic [KEY_WIDTH-1:0] kwdata;
    logic                 vwe;
    logic [IDX_W-1:0]     vwaddr;
    logic [VALUE_W-1:0]   vwdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [VALUE_W-1:0]   rd_value;

    logic                 hash_start;
    logic [HASH_W-1:0]    hash_key;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_slot;

    logic                 probe_hit;
    logic                 probe_empty;
    logic                 table_full;
    logic [CMP_W-1:0]     limit;
    logic [IDX_W-1:0]     hole_dist;
    logic [IDX_W-1:0]     pos_dist;
    logic [IDX_W-1:0]     ptr_inc;

    lphm_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (kwe),
        .waddr (kwaddr),
        .wdata (kwdata),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    lphm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (rd_addr),
        .rdata (rd_value)
    );

    lphm_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && (state_reg == S_IDLE);
    assign key_in_zero = (key[KEY_WIDTH-1:0] == '0);
    assign cfg_ready   = 1'b1;

    assign probe_hit   = (rd_key == key_reg);
    assign probe_empty = (rd_key == '0);
    assign ptr_inc     = ptr_reg + IDX_W'(1);

    // The limit in force never exceeds SLOTS - 1, so one slot stays empty.
    assign limit      = (CMP_W'(max_entries_reg) > CMP_W'(SLOTS - 1))
                        ? CMP_W'(SLOTS - 1) : CMP_W'(max_entries_reg);
    assign table_full = (CMP_W'(count_reg) >= limit);

    // A following key moves into the hole when the hole lies on its probe
    // path, that is, cyclically within [home, current slot).
    assign hole_dist = hole_reg - hash_slot;
    assign pos_dist  = ptr_reg - hash_slot;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        ptr_next        = ptr_reg;
        hole_next       = hole_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        status_next     = ST_OK;
        read_value_next = '0;
        mk_next         = mk_reg;
        mv_next         = mv_reg;
        kwe             = 1'b0;
        kwaddr          = ptr_reg;
        kwdata          = '0;
        vwe             = 1'b0;
        vwaddr          = ptr_reg;
        vwdata          = value_reg;
        rd_addr         = ptr_reg;
        hash_start      = 1'b0;
        hash_key        = HASH_W'(key[KEY_WIDTH-1:0]);

        unique case (state_reg)
            S_CLEAR:
            begin
                kwe      = 1'b1;
                kwaddr   = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (key_in_zero)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ZERO;
                    end
                    else
                    begin
                        unique case (cmd) inside
                            CMD_LOOKUP, CMD_SET, CMD_REMOVE:
                            begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                            default:
                            begin
                                done_next   = 1'b1;
                                status_next = ST_ABSENT;
                            end
                        endcase
                    end
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    rd_addr    = hash_slot;
                    ptr_next   = hash_slot;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (probe_hit || probe_empty)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    unique case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            if (probe_hit)
                            begin
                                read_value_next = rd_value;
                            end
                            else
                            begin
                                status_next = ST_ABSENT;
                            end
                        end
                        CMD_SET:
                        begin
                            if (probe_hit)
                            begin
                                vwe = 1'b1;
                            end
                            else if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                kwe        = 1'b1;
                                kwdata     = key_reg;
                                vwe        = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (probe_hit)
                            begin
                                // Empty the slot, then walk the rest of the cluster.
                                kwe        = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                hole_next  = ptr_reg;
                                ptr_next   = ptr_inc;
                                rd_addr    = ptr_inc;
                                done_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                status_next = ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_ABSENT;
                        end
                    endcase
                end
                else
                begin
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc;
                end
            end

            S_SCAN:
            begin
                if (rd_key == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mk_next    = rd_key;
                    mv_next    = rd_value;
                    hash_key   = HASH_W'(rd_key);
                    hash_start = 1'b1;
                    state_next = S_RHASH;
                end
            end

            S_RHASH:
            begin
                if (hash_done)
                begin
                    if (hole_dist < pos_dist)
                    begin
                        kwe        = 1'b1;
                        kwaddr     = hole_reg;
                        kwdata     = mk_reg;
                        vwe        = 1'b1;
                        vwaddr     = hole_reg;
                        vwdata     = mv_reg;
                        state_next = S_MVCLR;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        rd_addr    = ptr_inc;
                        state_next = S_SCAN;
                    end
                end
            end

            S_MVCLR:
            begin
                // The moved key's old slot becomes the new hole.
                kwe        = 1'b1;
                hole_next  = ptr_reg;
                ptr_next   = ptr_inc;
                rd_addr    = ptr_inc;
                state_next = S_SCAN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            ptr_reg         <= '0;
            hole_reg        <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ptr_reg   <= ptr_next;
            hole_reg  <= hole_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key[KEY_WIDTH-1:0];
            value_reg <= value;
        end
        mk_reg         <= mk_next;
        mv_reg         <= mv_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign read_value   = read_value_reg;
    assign stored_count = COUNT_OUT_W'(count_reg);

    a_no_result_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done
    ) else $error("result strobe during memory clear");

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(SLOTS - 1)
    ) else $error("entry count exceeds SLOTS - 1");

    a_zero_key_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && key_in_zero) |=> (done && status == ST_ZERO)
    ) else $error("zero key not answered in the next cycle");

    a_hash_done_expected: assert property (
        @(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH || state_reg == S_RHASH)
    ) else $error("hash result arrived while not awaited");

endmodule

// ===== design/lphm_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lphm_hash.sv =====
// ============================================================================
// Home slot hash unit
// Runs the 64-bit finalizer with one shared 32x32 multiplier. Each 64-bit
// product (mod 2^64) is built from three partial products, one after another.
// ============================================================================
module lphm_hash #(
    parameter int SLOTS = lphm_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lphm_pkg::HASH_W-1:0]   key,
    output logic                          done,
    output logic [$clog2(SLOTS)-1:0]      slot
);

    import lphm_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int HALF_W = HASH_W / 2;

    logic              run_reg;
    logic              run_next;
    logic              round_reg;
    logic              round_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              done_reg;
    logic              done_next;
    logic [HASH_W-1:0] z_reg;
    logic [HASH_W-1:0] z_next;
    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] prod_reg;
    logic [HASH_W-1:0] prod_next;
    logic [HASH_W-1:0] mix_const;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [HASH_W-1:0] sum;

    always_comb
    begin
        mix_const = round_reg ? MIX_C2 : MIX_C1;
        mul_a     = (step_reg == 2'd1) ? z_reg[HASH_W-1:HALF_W] : z_reg[HALF_W-1:0];
        mul_b     = (step_reg == 2'd2) ? mix_const[HASH_W-1:HALF_W]
                                       : mix_const[HALF_W-1:0];
        sum       = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

        run_next   = run_reg;
        round_next = round_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        z_next     = z_reg;
        acc_next   = acc_reg;
        prod_next  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

        if (start)
        begin
            run_next   = 1'b1;
            round_next = 1'b0;
            step_next  = 2'd0;
            z_next     = key ^ (key >> MIX_SH0);
        end
        else if (run_reg)
        begin
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd1:    acc_next = prod_reg;
                2'd2:    acc_next = sum;
                2'd3:
                begin
                    if (round_reg)
                    begin
                        z_next    = sum ^ (sum >> MIX_SH2);
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        z_next     = sum ^ (sum >> MIX_SH1);
                        round_next = 1'b1;
                    end
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            round_reg <= 1'b0;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            round_reg <= round_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign slot = z_reg[IDX_W-1:0];

endmodule
